FILE: design/sws_pkg.sv
package sws_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_OVER = 2'd3;

    // One result word as it leaves the block
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_val;
        logic [7:0] count;
        logic       last;
    } res_t;

    // One queue entry: the one or two results caused by a single character
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } act_t;

    localparam res_t RES_NONE = '{kind: KIND_DATA, byte_val: 8'd0, count: 8'd0, last: 1'b0};

endpackage

FILE: design/sws_lexer.sv
module sws_lexer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [7:0]       cfg_data,
    input  logic             accept,
    input  logic [7:0]       char_in,
    input  logic             end_of_line,
    output logic             act_valid,
    output sws_pkg::act_t    act
);
    import sws_pkg::*;

    typedef enum logic [6:0] {
        ST_BLANK  = 7'b0000001,
        ST_WORD   = 7'b0000010,
        ST_SQUOTE = 7'b0000100,
        ST_DQUOTE = 7'b0001000,
        ST_ESC0   = 7'b0010000,
        ST_ESC1   = 7'b0100000,
        ST_ESC2   = 7'b1000000
    } lex_state_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    lex_state_t st_reg, st_next;
    logic       saved_reg, saved_next;     // 1: return to double quote
    logic [7:0] acc_reg, acc_next;
    logic [7:0] left_reg, left_next;
    logic       ovf_reg, ovf_next;
    logic [7:0] max_words_reg;

    logic       is_blank, is_oct;
    logic [2:0] digit;

    // Plain handling of the character in word or double-quote mode
    logic       pl_dq;
    lex_state_t pl_state;
    logic       pl_saved;
    logic       pl_emit;
    res_t       pl_res;

    res_t       r0, r1;
    logic [1:0] n_res;

    // Character classes
    assign is_blank = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
    assign is_oct   = (char_in >= CH_ZERO) && (char_in <= CH_SEVEN);
    assign digit    = char_in[2:0];

    // Mode for plain handling: current quote, restored mode after escape, or new word
    always_comb
    begin
        case (st_reg)
            ST_DQUOTE:       pl_dq = 1'b1;
            ST_ESC1,ST_ESC2: pl_dq = saved_reg;
            default:         pl_dq = 1'b0;
        endcase
    end

    always_comb
    begin
        pl_saved = saved_reg;
        pl_emit  = 1'b0;
        pl_res   = RES_NONE;
        if (pl_dq) begin
            pl_state = ST_DQUOTE;
            if (char_in == CH_BSLASH) begin
                pl_saved = 1'b1;
                pl_state = ST_ESC0;
            end
            else if (char_in == CH_DQUOTE) begin
                pl_state = ST_WORD;
            end
            else begin
                pl_emit         = 1'b1;
                pl_res.byte_val = char_in;
            end
        end
        else begin
            pl_state = ST_WORD;
            if (is_blank) begin
                pl_state    = ST_BLANK;
                pl_emit     = 1'b1;
                pl_res.kind = KIND_END;
            end
            else if (char_in == CH_SQUOTE) begin
                pl_state = ST_SQUOTE;
            end
            else if (char_in == CH_DQUOTE) begin
                pl_state = ST_DQUOTE;
            end
            else if (char_in == CH_BSLASH) begin
                pl_saved = 1'b0;
                pl_state = ST_ESC0;
            end
            else begin
                pl_emit         = 1'b1;
                pl_res.byte_val = char_in;
            end
        end
    end

    // Next state and results for the incoming word
    always_comb
    begin
        st_next    = st_reg;
        saved_next = saved_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        ovf_next   = ovf_reg;
        r0         = RES_NONE;
        r1         = RES_NONE;
        n_res      = 2'd0;

        if (end_of_line) begin
            if (!ovf_reg) begin
                if (st_reg != ST_BLANK) begin
                    r0.kind  = KIND_END;
                    r1.kind  = KIND_DONE;
                    r1.count = max_words_reg - left_reg;
                    r1.last  = 1'b1;
                    n_res    = 2'd2;
                end
                else begin
                    r0.kind  = KIND_DONE;
                    r0.count = max_words_reg - left_reg;
                    r0.last  = 1'b1;
                    n_res    = 2'd1;
                end
            end
            st_next    = ST_BLANK;
            saved_next = 1'b0;
            acc_next   = 8'd0;
            left_next  = max_words_reg;
            ovf_next   = 1'b0;
        end
        else if (!ovf_reg) begin
            case (st_reg)
                ST_WORD, ST_DQUOTE:
                begin
                    st_next    = pl_state;
                    saved_next = pl_saved;
                    r0         = pl_res;
                    n_res      = {1'b0, pl_emit};
                end
                ST_SQUOTE:
                begin
                    if (char_in == CH_SQUOTE) begin
                        st_next = ST_WORD;
                    end
                    else begin
                        r0.byte_val = char_in;
                        n_res       = 2'd1;
                    end
                end
                ST_ESC0:
                begin
                    st_next = saved_reg ? ST_DQUOTE : ST_WORD;
                    n_res   = 2'd1;
                    case (char_in)
                        CH_B:    r0.byte_val = 8'd8;
                        CH_F:    r0.byte_val = 8'd12;
                        CH_N:    r0.byte_val = 8'd10;
                        CH_R:    r0.byte_val = 8'd13;
                        CH_T:    r0.byte_val = 8'd9;
                        default: r0.byte_val = char_in;
                    endcase
                    if (is_oct) begin
                        acc_next = {5'd0, digit};
                        st_next  = ST_ESC1;
                        n_res    = 2'd0;
                    end
                end
                ST_ESC1:
                begin
                    if (is_oct) begin
                        acc_next = {acc_reg[4:0], digit};
                        st_next  = ST_ESC2;
                    end
                    else begin
                        r0.byte_val = acc_reg;
                        r1          = pl_res;
                        n_res       = pl_emit ? 2'd2 : 2'd1;
                        st_next     = pl_state;
                        saved_next  = pl_saved;
                    end
                end
                ST_ESC2:
                begin
                    n_res = 2'd1;
                    if (is_oct) begin
                        acc_next    = {acc_reg[4:0], digit};
                        r0.byte_val = {acc_reg[4:0], digit};
                        st_next     = saved_reg ? ST_DQUOTE : ST_WORD;
                    end
                    else begin
                        r0.byte_val = acc_reg;
                        r1          = pl_res;
                        n_res       = pl_emit ? 2'd2 : 2'd1;
                        st_next     = pl_state;
                        saved_next  = pl_saved;
                    end
                end
                default:
                begin
                    // Outside a word
                    if (is_blank) begin
                        st_next = ST_BLANK;
                    end
                    else if (left_reg == 8'd0) begin
                        ovf_next = 1'b1;
                        st_next  = ST_BLANK;
                        r0.kind  = KIND_OVER;
                        r0.last  = 1'b1;
                        n_res    = 2'd1;
                    end
                    else begin
                        left_next  = left_reg - 8'd1;
                        st_next    = pl_state;
                        saved_next = pl_saved;
                        r0         = pl_res;
                        n_res      = {1'b0, pl_emit};
                    end
                end
            endcase
        end
    end

    assign act_valid = accept && (n_res != 2'd0);
    assign act.two   = (n_res == 2'd2);
    assign act.r0    = r0;
    assign act.r1    = r1;

    // Lexer state; a register write restarts the line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg        <= ST_BLANK;
            saved_reg     <= 1'b0;
            acc_reg       <= 8'd0;
            left_reg      <= 8'd255;
            ovf_reg       <= 1'b0;
            max_words_reg <= 8'd255;
        end
        else if (cfg_write) begin
            st_reg        <= ST_BLANK;
            saved_reg     <= 1'b0;
            acc_reg       <= 8'd0;
            left_reg      <= cfg_data;
            ovf_reg       <= 1'b0;
            max_words_reg <= cfg_data;
        end
        else if (accept) begin
            st_reg    <= st_next;
            saved_reg <= saved_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

FILE: design/sws_fifo.sv
module sws_fifo #(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sws_pkg::act_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output sws_pkg::act_t rd_data,
    output logic          not_empty
);
    import sws_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    act_t          entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = entries_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: design/sws_emitter.sv
module sws_emitter
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  sws_pkg::act_t head,
    output logic          head_pop,
    output logic          empty,
    input  logic          pop,
    output sws_pkg::res_t out_res
);
    import sws_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic phase_reg, phase_next;          // 1: second result of head still to go
    res_t out_res_reg, out_res_next;
    logic load;

    assign load  = !out_valid_reg || pop;
    assign empty = !out_valid_reg;
    assign out_res = out_res_reg;

    // Unpack queue entries one result at a time into the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        out_res_next   = out_res_reg;
        head_pop       = 1'b0;
        if (load) begin
            out_valid_next = head_valid;
            if (head_valid) begin
                out_res_next = phase_reg ? head.r1 : head.r0;
                if (head.two && !phase_reg) begin
                    phase_next = 1'b1;
                end
                else begin
                    phase_next = 1'b0;
                    head_pop   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

endmodule

FILE: design/shell_word_splitter_core.sv
// Channel   | Signals                                  | Transfer
// ----------+------------------------------------------+----------------------
// input     | push, full, char_in, end_of_line         | push & !full
// result    | empty, pop, kind, byte_out, word_count,  | pop & !empty
//           | last                                     |
// config    | cfg_write, cfg_data (max_words)          | cfg_write
//
// One word accepted per cycle while the action queue has room; a character that
// causes two results (octal escape closed by a character that also gives a result,
// or end of line inside a word) occupies the single output register for both
// results in turn, so that output port sets the sustained rate. The first result
// passes through the queue and then the output register on its way to the ports.
// Reset restores max_words to 255 and starts a fresh line; a stalled result
// side fills the QUEUE_DEPTH-entry queue and then raises full.
module shell_word_splitter_core #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    input  logic       end_of_line,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] kind,
    output logic [7:0] byte_out,
    output logic [7:0] word_count,
    output logic       last,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data
);
    import sws_pkg::*;

    logic accept;
    logic act_valid;
    act_t act;
    act_t head;
    logic head_valid;
    logic head_pop;
    res_t out_res;

    assign accept = push && !full;

    // Front: classify characters and queue their results
    sws_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .char_in     (char_in),
        .end_of_line (end_of_line),
        .act_valid   (act_valid),
        .act         (act)
    );

    sws_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (act_valid),
        .wr_data   (act),
        .full      (full),
        .rd_en     (head_pop),
        .rd_data   (head),
        .not_empty (head_valid)
    );

    // Back: hand out results one at a time
    sws_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .out_res    (out_res)
    );

    assign kind       = out_res.kind;
    assign byte_out   = out_res.byte_val;
    assign word_count = out_res.count;
    assign last       = out_res.last;

endmodule
